[sv/pfdv_pkg.sv]
// Package: shared types, phase codes and constants for the frame deframer/validator.
package pfdv_pkg;

    localparam int unsigned FPRINT_W = 64;
    localparam int unsigned LEN_W    = 32;

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_ID     = 4'd1,
        PH_LENGTH = 4'd2,
        PH_FPRINT = 4'd3,
        PH_CLEN   = 4'd4,
        PH_CBYTE  = 4'd5,
        PH_DLEN   = 4'd6,
        PH_DBYTE  = 4'd7,
        PH_EXTRA  = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [3:0]  field_kind;
        logic        is_last;
        logic        frame_ok;
        logic        is_response;
        logic [31:0] req_id;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic resp, input logic [1:0] pos);
        logic [7:0] v;
        unique case (pos)
            2'd0:    v = 8'h41;
            2'd1:    v = 8'h55;
            2'd2:    v = 8'h44;
            default: v = resp ? 8'h52 : 8'h51;
        endcase
        return v;
    endfunction

endpackage

[sv/pfdv_byte_if.sv]
// Interface: input byte channel with valid/ready handshake.
interface pfdv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

[sv/pfdv_result_if.sv]
// Interface: tagged result word channel with valid/ready handshake.
interface pfdv_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [3:0]  field_kind;
    logic        is_last;
    logic        frame_ok;
    logic        is_response;
    logic [31:0] req_id;

    modport source (output valid, output byte_value, output field_kind, output is_last,
                    output frame_ok, output is_response, output req_id, input ready);
    modport sink   (input valid, input byte_value, input field_kind, input is_last,
                    input frame_ok, input is_response, input req_id, output ready);
endinterface

[sv/proxy_frame_deframer_validator.sv]
// Top level: proxy frame deframer and validator.
// Usage:
//   i_byte takes one packet byte per word, end_of_packet set on the final byte.
//   o_result returns one tagged word per input byte: the byte, its field kind,
//   the end mark, frame_ok on the closing word, the response flag and the
//   request id gathered so far.
//   i_cfg_we / i_cfg_wdata load the expected 64-bit fingerprint; write it only
//   while no words are in flight.
// Timing:
//   One byte is accepted per clock while i_byte.ready is high. The parser
//   forms each result combinationally, and the result is registered into a
//   two-entry output buffer (result register plus skid register).
// Reset:
//   Synchronous active-low reset clears the fingerprint to zero, returns the
//   parser to the magic field and empties the output buffer.
// Stall:
//   When o_result is held off, up to two results wait in the buffer and
//   i_byte.ready drops only once both entries are full.
module proxy_frame_deframer_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfdv_pkg::FPRINT_W-1:0] i_cfg_wdata,
    pfdv_byte_if.sink                     i_byte,
    pfdv_result_if.source                 o_result
);

    pfdv_pkg::t_result parsed;
    pfdv_pkg::t_result held;
    logic              can_push;
    logic              accept;

    assign i_byte.ready = can_push;
    assign accept       = i_byte.valid && can_push;

    pfdv_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (i_byte.data_byte),
        .i_end_of_packet (i_byte.end_of_packet),
        .o_result        (parsed)
    );

    pfdv_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_result   (parsed),
        .o_can_push (can_push),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_result   (held)
    );

    assign o_result.byte_value  = held.byte_value;
    assign o_result.field_kind  = held.field_kind;
    assign o_result.is_last     = held.is_last;
    assign o_result.frame_ok    = held.frame_ok;
    assign o_result.is_response = held.is_response;
    assign o_result.req_id      = held.req_id;

endmodule

[sv/pfdv_parser.sv]
// Parser: per-byte field tracking, checks and result word generation.
module pfdv_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfdv_pkg::FPRINT_W-1:0]      i_cfg_wdata,
    input  logic                               i_accept,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_end_of_packet,
    output pfdv_pkg::t_result                  o_result
);

    logic [pfdv_pkg::FPRINT_W-1:0] r_fprint;
    pfdv_pkg::t_phase              r_phase, n_phase;
    logic [2:0]                    r_count, n_count;
    logic [63:0]                   r_shift, n_shift;
    logic [31:0]                   r_id, n_id;
    logic                          r_resp, n_resp;
    logic                          r_req, n_req;
    logic [pfdv_pkg::LEN_W-1:0]    r_pay, n_pay;
    logic [pfdv_pkg::LEN_W-1:0]    r_str, n_str;
    logic                          r_err, n_err;

    logic [63:0] sh;
    logic [2:0]  cnt;
    logic        done4;
    logic        done8;
    logic [31:0] pay_dec;
    logic        pay_under;
    logic [31:0] str_dec;
    logic [31:0] new_len;
    logic [3:0]  kind;
    logic        ok;

    assign sh        = {r_shift[55:0], i_data_byte};
    assign cnt       = r_count + 3'd1;
    assign done4     = (cnt == 3'd4);
    assign done8     = (cnt == 3'd0);
    assign pay_under = (r_pay == '0);
    assign pay_dec   = pay_under ? r_pay : r_pay - 32'd1;
    assign str_dec   = r_str - 32'd1;
    assign new_len   = sh[31:0];

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_shift = r_shift;
        n_id    = r_id;
        n_resp  = r_resp;
        n_req   = r_req;
        n_pay   = r_pay;
        n_str   = r_str;
        n_err   = r_err;
        kind    = 4'(pfdv_pkg::PH_EXTRA);
        unique case (r_phase)
            pfdv_pkg::PH_MAGIC: begin
                kind    = 4'(pfdv_pkg::PH_MAGIC);
                n_resp  = (pfdv_pkg::magic_byte(1'b1, r_count[1:0]) == i_data_byte)
                          && (r_count[1:0] == 2'd0 || r_resp);
                n_req   = (pfdv_pkg::magic_byte(1'b0, r_count[1:0]) == i_data_byte)
                          && (r_count[1:0] == 2'd0 || r_req);
                n_shift = sh;
                n_count = cnt;
                if (done4) begin
                    n_count = '0;
                    n_shift = '0;
                    n_phase = pfdv_pkg::PH_ID;
                    if (!n_resp && !n_req) begin
                        n_err = 1'b1;
                    end
                end
            end
            pfdv_pkg::PH_ID: begin
                kind    = 4'(pfdv_pkg::PH_ID);
                n_id    = {r_id[23:0], i_data_byte};
                n_shift = sh;
                n_count = cnt;
                if (done4) begin
                    n_count = '0;
                    n_shift = '0;
                    n_phase = pfdv_pkg::PH_LENGTH;
                end
            end
            pfdv_pkg::PH_LENGTH: begin
                kind    = 4'(pfdv_pkg::PH_LENGTH);
                n_shift = sh;
                n_count = cnt;
                if (done4) begin
                    n_count = '0;
                    n_pay   = new_len;
                    n_shift = '0;
                    n_phase = pfdv_pkg::PH_FPRINT;
                end
            end
            pfdv_pkg::PH_FPRINT: begin
                kind    = 4'(pfdv_pkg::PH_FPRINT);
                n_pay   = pay_dec;
                n_err   = r_err | pay_under;
                n_shift = sh;
                n_count = cnt;
                if (done8) begin
                    if (sh != r_fprint) begin
                        n_err = 1'b1;
                    end
                    n_shift = '0;
                    n_phase = pfdv_pkg::PH_CLEN;
                end
            end
            pfdv_pkg::PH_CLEN, pfdv_pkg::PH_DLEN: begin
                kind    = 4'(r_phase);
                n_pay   = pay_dec;
                n_err   = r_err | pay_under;
                n_shift = sh;
                n_count = cnt;
                if (done4) begin
                    n_count = '0;
                    n_str   = new_len;
                    n_shift = '0;
                    if (new_len == '0 || new_len > pay_dec) begin
                        n_err   = 1'b1;
                        n_phase = pfdv_pkg::PH_EXTRA;
                    end else if (r_phase == pfdv_pkg::PH_CLEN) begin
                        n_phase = pfdv_pkg::PH_CBYTE;
                    end else begin
                        n_phase = pfdv_pkg::PH_DBYTE;
                    end
                end
            end
            pfdv_pkg::PH_CBYTE, pfdv_pkg::PH_DBYTE: begin
                kind  = 4'(r_phase);
                n_pay = pay_dec;
                n_err = r_err | pay_under;
                n_str = str_dec;
                if (str_dec == '0) begin
                    if (i_data_byte != 8'd0) begin
                        n_err = 1'b1;
                    end
                    n_phase = (r_phase == pfdv_pkg::PH_CBYTE) ? pfdv_pkg::PH_DLEN
                                                              : pfdv_pkg::PH_EXTRA;
                end
            end
            default: begin
                kind    = 4'(pfdv_pkg::PH_EXTRA);
                n_phase = pfdv_pkg::PH_EXTRA;
                n_err   = 1'b1;
            end
        endcase
        ok = i_end_of_packet && !n_err && (n_phase == pfdv_pkg::PH_EXTRA) && (n_pay == '0);
    end

    always_comb begin
        o_result.byte_value  = i_data_byte;
        o_result.field_kind  = kind;
        o_result.is_last     = i_end_of_packet;
        o_result.frame_ok    = ok;
        o_result.is_response = n_resp;
        o_result.req_id      = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fprint <= '0;
        end else if (i_cfg_we) begin
            r_fprint <= i_cfg_wdata;
        end
    end

    // clear parse state at reset and after the closing word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_packet)) begin
            r_phase <= pfdv_pkg::PH_MAGIC;
            r_count <= '0;
            r_shift <= '0;
            r_id    <= '0;
            r_resp  <= 1'b0;
            r_req   <= 1'b0;
            r_pay   <= '0;
            r_str   <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            r_id    <= n_id;
            r_resp  <= n_resp;
            r_req   <= n_req;
            r_pay   <= n_pay;
            r_str   <= n_str;
            r_err   <= n_err;
        end
    end

endmodule

[sv/pfdv_out_buf.sv]
// Output buffer: result register plus skid register, registered ready.
module pfdv_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pfdv_pkg::t_result i_result,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output pfdv_pkg::t_result o_result
);

    logic              r_main_valid;
    logic              r_skid_valid;
    pfdv_pkg::t_result r_main;
    pfdv_pkg::t_result r_skid;
    logic              pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_result   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (r_main_valid && !pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_main_valid <= 1'b1;
                end
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end else begin
                r_main_valid <= r_main_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end else begin
            r_main <= r_main;
        end
    end

endmodule
